// File: src/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: label");

// Whenever the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, trig, cons)

`endif

`endif

// File: src/iptv_pkg.sv
`timescale 1ns / 1ps

package iptv_pkg;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_LC_A  = 8'h61;
  localparam logic [7:0] CHR_LC_F  = 8'h66;
  localparam logic [7:0] CHR_UC_A  = 8'h41;
  localparam logic [7:0] CHR_UC_F  = 8'h46;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_COLON = 8'h3A;

  localparam logic [11:0] OCTET_MAX     = 12'd255;
  localparam logic [1:0]  OCTET_DIGITS  = 2'd3;
  localparam logic [2:0]  DOTS_IN_QUAD  = 3'd3;
  localparam logic [2:0]  GROUP_DIGITS  = 3'd4;
  localparam logic [4:0]  GROUPS_MAX    = 5'd8;
  localparam logic [1:0]  TAIL_GROUPS   = 2'd2;

  localparam logic FAMILY_IPV4 = 1'b0;

  // Per-string parsing state.
  typedef struct packed {
    logic       failed;
    logic [7:0] octet_value;
    logic [1:0] octet_digit_count;
    logic       octet_leading_zero;
    logic [2:0] octets_seen;
    logic [2:0] hex_digit_count;
    logic [3:0] groups_before_elision;
    logic [3:0] groups_after_elision;
    logic       elision_seen;
    logic       previous_was_colon;
    logic       in_dotted_tail;
    logic       at_string_start;
  } str_state_t;

  localparam str_state_t STATE_RESET = '{
    failed:                1'b0,
    octet_value:           8'd0,
    octet_digit_count:     2'd0,
    octet_leading_zero:    1'b0,
    octets_seen:           3'd0,
    hex_digit_count:       3'd0,
    groups_before_elision: 4'd0,
    groups_after_elision:  4'd0,
    elision_seen:          1'b0,
    previous_was_colon:    1'b0,
    in_dotted_tail:        1'b0,
    at_string_start:       1'b1
  };

  // Control word from the register port to the datapath.
  typedef struct packed {
    logic family;
    logic clear;
  } cfg_ctrl_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CHR_LC_A) && (c <= CHR_LC_F)) ||
           ((c >= CHR_UC_A) && (c <= CHR_UC_F));
  endfunction

  // value * 10 + digit, with shifts and adds; only meaningful for a decimal digit.
  function automatic logic [11:0] dec_accum(input logic [7:0] value, input logic [7:0] c);
    logic [11:0] wide;
    wide = {4'd0, value};
    return (wide << 3) + (wide << 1) + {8'd0, c[3:0]};
  endfunction

endpackage

// File: src/iptv_cfg.sv
`timescale 1ns / 1ps

module iptv_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output iptv_pkg::cfg_ctrl_t ctrl
);

  logic family;
  logic wr;

  assign pready = 1'b1;
  // Only one register: every byte address of the word selects it.
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      family <= iptv_pkg::FAMILY_IPV4;
    end else if (wr) begin
      family <= pwdata[0];
    end
  end

  always_comb begin
    prdata = {31'd0, family};
    if (paddr != 2'd0) begin
      prdata = {31'd0, family};
    end
  end

  assign ctrl.family = family;
  assign ctrl.clear  = wr;

endmodule

// File: src/iptv_step.sv
`timescale 1ns / 1ps

module iptv_step (
  input  iptv_pkg::str_state_t state,
  input  logic                 family,
  input  logic [7:0]           text_byte,
  input  logic                 last,
  input  logic                 empty,
  output iptv_pkg::str_state_t state_next,
  output logic                 valid_word
);

  function automatic iptv_pkg::str_state_t dotted_byte(input iptv_pkg::str_state_t s,
                                                       input logic [7:0] c);
    iptv_pkg::str_state_t r;
    logic [11:0]          v;
    r = s;
    v = iptv_pkg::dec_accum(s.octet_value, c);
    if (iptv_pkg::is_dec(c)) begin
      if (s.octet_digit_count == iptv_pkg::OCTET_DIGITS ||
          (s.octet_digit_count != 2'd0 && s.octet_leading_zero) ||
          v > iptv_pkg::OCTET_MAX) begin
        r.failed = 1'b1;
      end else begin
        if (s.octet_digit_count == 2'd0) begin
          r.octet_leading_zero = (c == iptv_pkg::CHR_ZERO);
        end
        r.octet_value       = v[7:0];
        r.octet_digit_count = s.octet_digit_count + 2'd1;
      end
    end else if (c == iptv_pkg::CHR_DOT) begin
      if (s.octet_digit_count == 2'd0 || s.octets_seen >= iptv_pkg::DOTS_IN_QUAD) begin
        r.failed = 1'b1;
      end else begin
        r.octets_seen        = s.octets_seen + 3'd1;
        r.octet_value        = 8'd0;
        r.octet_digit_count  = 2'd0;
        r.octet_leading_zero = 1'b0;
      end
    end else begin
      r.failed = 1'b1;
    end
    return r;
  endfunction

  function automatic iptv_pkg::str_state_t v6_byte(input iptv_pkg::str_state_t s,
                                                   input logic [7:0] c);
    iptv_pkg::str_state_t r;
    logic [11:0]          v;
    logic [4:0]           side;
    r    = s;
    v    = iptv_pkg::dec_accum(s.octet_value, c);
    side = {1'b0, s.elision_seen ? s.groups_after_elision : s.groups_before_elision} + 5'd1;
    if (s.in_dotted_tail) begin
      r = dotted_byte(s, c);
    end else if (c == iptv_pkg::CHR_COLON) begin
      if (s.previous_was_colon) begin
        if (s.elision_seen) begin
          r.failed = 1'b1;
        end
        r.elision_seen = 1'b1;
      end else if (!s.at_string_start) begin
        if (s.hex_digit_count == 3'd0 || side > iptv_pkg::GROUPS_MAX) begin
          r.failed = 1'b1;
        end else if (s.elision_seen) begin
          r.groups_after_elision = side[3:0];
        end else begin
          r.groups_before_elision = side[3:0];
        end
      end
      r.previous_was_colon = 1'b1;
      r.hex_digit_count    = 3'd0;
      r.octet_value        = 8'd0;
      r.octet_digit_count  = 2'd0;
      r.octet_leading_zero = 1'b0;
    end else if (s.previous_was_colon && !s.elision_seen && s.groups_before_elision == 4'd0) begin
      // A single colon opening the string.
      r.failed = 1'b1;
    end else begin
      r.previous_was_colon = 1'b0;
      if (c == iptv_pkg::CHR_DOT) begin
        if (s.hex_digit_count == 3'd0 || {1'b0, s.octet_digit_count} != s.hex_digit_count ||
            (s.octet_leading_zero && s.octet_digit_count > 2'd1)) begin
          r.failed = 1'b1;
        end else begin
          r.in_dotted_tail     = 1'b1;
          r.octets_seen        = 3'd1;
          r.octet_value        = 8'd0;
          r.octet_digit_count  = 2'd0;
          r.octet_leading_zero = 1'b0;
        end
      end else if (!iptv_pkg::is_hex(c) || s.hex_digit_count >= iptv_pkg::GROUP_DIGITS) begin
        r.failed = 1'b1;
      end else begin
        // The octet fields shadow the group while it still reads as a decimal octet.
        if (iptv_pkg::is_dec(c) && {1'b0, s.octet_digit_count} == s.hex_digit_count &&
            s.octet_digit_count < iptv_pkg::OCTET_DIGITS && v <= iptv_pkg::OCTET_MAX) begin
          if (s.octet_digit_count == 2'd0) begin
            r.octet_leading_zero = (c == iptv_pkg::CHR_ZERO);
          end
          r.octet_value       = v[7:0];
          r.octet_digit_count = s.octet_digit_count + 2'd1;
        end
        r.hex_digit_count = s.hex_digit_count + 3'd1;
      end
    end
    return r;
  endfunction

  iptv_pkg::str_state_t n;
  logic [1:0]           add_count;
  logic                 shape_ok;
  logic [4:0]           side_sum;
  logic [3:0]           gb_final;
  logic [3:0]           ga_final;
  logic [4:0]           total;
  logic                 v4_ok;
  logic                 v6_ok;

  always_comb begin
    n = state;
    if (!state.failed) begin
      if (family == iptv_pkg::FAMILY_IPV4) begin
        n = dotted_byte(state, text_byte);
      end else begin
        n = v6_byte(state, text_byte);
      end
    end
    n.at_string_start = 1'b0;
  end

  // Closing checks for a string that ends with this byte.
  always_comb begin
    add_count = 2'd0;
    shape_ok  = 1'b1;
    if (n.previous_was_colon) begin
      shape_ok = n.elision_seen && n.groups_after_elision == 4'd0 && n.hex_digit_count == 3'd0;
    end else if (n.in_dotted_tail) begin
      shape_ok  = n.octet_digit_count != 2'd0 && n.octets_seen == iptv_pkg::DOTS_IN_QUAD;
      add_count = iptv_pkg::TAIL_GROUPS;
    end else begin
      shape_ok  = n.hex_digit_count != 3'd0;
      add_count = 2'd1;
    end
    side_sum = {1'b0, n.elision_seen ? n.groups_after_elision : n.groups_before_elision} +
               {3'd0, add_count};
    gb_final = n.elision_seen ? n.groups_before_elision : side_sum[3:0];
    ga_final = n.elision_seen ? side_sum[3:0] : n.groups_after_elision;
    total    = {1'b0, gb_final} + {1'b0, ga_final};
    v4_ok    = n.octet_digit_count != 2'd0 && n.octets_seen == iptv_pkg::DOTS_IN_QUAD;
    v6_ok    = shape_ok && side_sum <= iptv_pkg::GROUPS_MAX &&
               (n.elision_seen ? (total < iptv_pkg::GROUPS_MAX)
                               : ({1'b0, gb_final} == iptv_pkg::GROUPS_MAX));
  end

  always_comb begin
    valid_word = 1'b0;
    state_next = n;
    if (empty) begin
      state_next = iptv_pkg::STATE_RESET;
    end else if (last) begin
      valid_word = !n.failed && ((family == iptv_pkg::FAMILY_IPV4) ? v4_ok : v6_ok);
      state_next = iptv_pkg::STATE_RESET;
    end
  end

endmodule

// File: src/ip_address_text_validator.sv
`timescale 1ns / 1ps
// Streaming validator for IPv4 or IPv6 address text, one character byte per input word.
// A string ends with a word that has end_of_string or empty_string set, and only that word
// produces an output word carrying address_valid. The block takes one byte every cycle while
// in_ready is high: a byte goes into an input register and is checked there against the
// per-string state, and a terminating byte moves its verdict on into the output
// register, which raises out_valid. in_ready drops only while the output register
// holds an untaken result and the registered byte would produce another. The address_family
// register (offset 0) selects IPv4 (0) or IPv6 (1); writing it also abandons any string in
// progress, so write it only while the block is idle.
`include "assert_macros.svh"

module ip_address_text_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  input  logic        empty_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        address_valid
);

  iptv_pkg::cfg_ctrl_t  ctrl;
  iptv_pkg::str_state_t st;
  iptv_pkg::str_state_t st_next;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_empty;
  logic       s1_res;
  logic       s1_go;
  logic       step_valid;

  iptv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl    (ctrl)
  );

  iptv_step u_step (
    .state      (st),
    .family     (ctrl.family),
    .text_byte  (s1_byte),
    .last       (s1_last),
    .empty      (s1_empty),
    .state_next (st_next),
    .valid_word (step_valid)
  );

  assign s1_res   = s1_last || s1_empty;
  // A word that produces no result always moves on; one that does needs a free output slot.
  assign s1_go    = s1_valid && (!s1_res || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= text_byte;
      s1_last  <= end_of_string;
      s1_empty <= empty_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      st <= iptv_pkg::STATE_RESET;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_res) begin
      address_valid <= step_valid;
    end
  end

  `ASSERT_NEXT(a_result_loaded, clk, rst, s1_go && s1_res, out_valid)
  `ASSERT_NEXT(a_state_cleared, clk, rst, s1_go && s1_res, st.at_string_start && !st.failed)
  `ASSERT_NEXT(a_empty_invalid, clk, rst, s1_go && s1_empty, !address_valid)
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst, !(out_valid && !out_ready && s1_go && s1_res))

endmodule
